FILE: src/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg - shared types and constants for the SHA-1 stream hasher
// Sequencer states, item codes, round constants and the initial chaining value.
// ----------------------------------------------------------------------------
package sha1s_pkg;

    localparam int ROUNDS      = 80;
    localparam int DIGEST_WDS  = 5;

    // item kinds carried on the input tuser bit
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    typedef logic [31:0] t_word;
    typedef t_word t_cv [DIGEST_WDS];

    localparam t_cv H_INIT = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // working variables a..e of the compression
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

endpackage

FILE: src/sha1s_round.sv
// ----------------------------------------------------------------------------
// sha1s_round - one SHA-1 round
// Combinational round step, reused for all 80 rounds by the sequencer.
// ----------------------------------------------------------------------------
module sha1s_round
    import sha1s_pkg::*;
(
    input  t_work      i_work,
    input  t_word      i_w,
    input  logic [6:0] i_rnd,
    output t_work      o_work
);

    t_word f;
    t_word k;
    t_word t_sum;

    always_comb begin
        case (i_rnd) inside
            [7'd0:7'd19]: begin
                f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
                k = K_0;
            end
            [7'd20:7'd39]: begin
                f = i_work.b ^ i_work.c ^ i_work.d;
                k = K_1;
            end
            [7'd40:7'd59]: begin
                f = (i_work.b & i_work.c) | (i_work.b & i_work.d)
                  | (i_work.c & i_work.d);
                k = K_2;
            end
            default: begin
                f = i_work.b ^ i_work.c ^ i_work.d;
                k = K_3;
            end
        endcase
    end

    assign t_sum = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_w;

    assign o_work.a = t_sum;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;

endmodule

FILE: src/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher - SHA-1 over a byte stream
// Bytes in, five digest words out per finish transaction.
// ----------------------------------------------------------------------------
// Input transactions carry one byte in s_axis_tdata; s_axis_tuser selects
// append (0) or finish (1). Every 64th appended byte starts a block
// compression (80 rounds on one shared round unit, then one chaining
// add), during which no further byte is taken. A finish
// pads one byte per cycle (0x80, zeros, 64-bit big-endian bit count) up to
// the block end and compresses, once or twice: twice when 56 or more bytes
// of the current block were already filled. It then presents the digest as
// five output transactions, h0 first, word index in m_axis_tuser and tlast
// on h4. s_axis_tready is low while a block compresses, and from a finish
// until the last digest word is taken. After the digest the hasher is back
// at its initial chaining value with a zero byte count.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
    import sha1s_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] op
    // digest stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // final_word
);

    localparam logic [2:0] LAST_WD = 3'(DIGEST_WDS - 1);
    localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);

    t_state        r_state, n_state;
    logic [5:0]    r_pos;        // byte position in the current block
    logic [63:0]   r_cnt;        // message byte count
    logic          r_fin;        // finish in progress
    logic          r_last_blk;   // current padded block carries the bit count
    logic          r_first;      // next pad byte is the 0x80 marker
    logic [6:0]    r_rnd;
    logic [2:0]    r_widx;
    t_cv           r_h;
    t_work         r_work;
    logic [511:0]  r_blk;        // byte shift line, then 16-word schedule window

    logic          in_acc, out_acc;
    logic          is_append;
    t_work         work_nxt;
    t_word         w_new;
    logic [63:0]   len_bits, len_sh;
    logic [7:0]    pad_byte;

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign out_acc   = m_axis_tvalid & m_axis_tready;
    assign is_append = (s_axis_tuser[0] == OP_APPEND);

    // window holds w[t..t+15] with w[t] in the top word
    assign w_new = {r_blk[511-13*32 -: 32] ^ r_blk[511-8*32 -: 32]
                  ^ r_blk[511-2*32 -: 32] ^ r_blk[511 -: 32]};

    sha1s_round u_round (
        .i_work (r_work),
        .i_w    (r_blk[511 -: 32]),
        .i_rnd  (r_rnd),
        .o_work (work_nxt)
    );

    // big-endian bit count, byte picked by position within the last eight
    assign len_bits = {r_cnt[60:0], 3'b000};
    assign len_sh   = len_bits << {r_pos[2:0], 3'b000};

    always_comb begin
        if (r_first) begin
            pad_byte = PAD_MARK;
        end else if (r_last_blk && (r_pos[5:3] == 3'b111)) begin
            pad_byte = len_sh[63:56];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!is_append) begin
                        n_state = S_PAD;
                    end else if (r_pos == 6'd63) begin
                        n_state = S_ROUND;
                    end
                end
            end
            S_PAD: begin
                if (r_pos == 6'd63) n_state = S_ROUND;
            end
            S_ROUND: begin
                if (r_rnd == LAST_RND) n_state = S_ADD;
            end
            S_ADD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_last_blk) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (out_acc && (r_widx == LAST_WD)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_EMIT);
        m_axis_tdata  = r_h[0];
        m_axis_tuser  = r_widx;
        m_axis_tlast  = (r_widx == LAST_WD);
    end

    // control state and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_fin      <= 1'b0;
            r_last_blk <= 1'b0;
            r_first    <= 1'b0;
            r_rnd      <= '0;
            r_widx     <= '0;
            r_h        <= H_INIT;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_append) begin
                            r_pos <= r_pos + 6'd1;
                            r_cnt <= r_cnt + 64'd1;
                            r_rnd <= '0;
                        end else begin
                            r_fin      <= 1'b1;
                            r_first    <= 1'b1;
                            r_last_blk <= (r_pos < 6'd56);
                        end
                    end
                end
                S_PAD: begin
                    r_pos   <= r_pos + 6'd1;
                    r_first <= 1'b0;
                    r_rnd   <= '0;
                end
                S_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_work.a;
                    r_h[1] <= r_h[1] + r_work.b;
                    r_h[2] <= r_h[2] + r_work.c;
                    r_h[3] <= r_h[3] + r_work.d;
                    r_h[4] <= r_h[4] + r_work.e;
                    if (r_fin) r_last_blk <= 1'b1;
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (r_widx == LAST_WD) begin
                            r_h    <= H_INIT;
                            r_cnt  <= '0;
                            r_fin  <= 1'b0;
                            r_widx <= '0;
                        end else begin
                            r_h[0] <= r_h[1];
                            r_h[1] <= r_h[2];
                            r_h[2] <= r_h[3];
                            r_h[3] <= r_h[4];
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: block shift line and working variables
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_append) begin
                    r_blk  <= {r_blk[503:0], s_axis_tdata};
                    r_work <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
                end
            end
            S_PAD: begin
                r_blk  <= {r_blk[503:0], pad_byte};
                r_work <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};
            end
            S_ROUND: begin
                r_blk  <= {r_blk[479:0], w_new[30:0], w_new[31]};
                r_work <= work_nxt;
            end
            default: ;
        endcase
    end

    // ---- assertions ----
    // input and output sides are never open at once
    a_sides_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest presented");

    // every compression starts on a block boundary
    a_block_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) && (n_state == S_ROUND) |=> (r_pos == 6'd0))
        else $error("compression started mid-block");

    // taking the last digest word restarts the message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && m_axis_tlast |=> (r_cnt == 64'd0) && (r_h[0] == H_INIT[0])
                                    && s_axis_tready)
        else $error("hasher not restarted after digest");

    // digest words follow in index order without a gap
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
                    || $past(m_axis_tlast))
        else $error("digest words out of order");

endmodule
